/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the frame transmitter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/ootx_pkg.sv */
// ----------------------------------------------------------------------------
// ootx_pkg
// Types and constants shared by the on/off keyed frame transmitter.
// ----------------------------------------------------------------------------
package ootx_pkg;

  // Address symbols per frame (two bits each) and timer width
  localparam int AddressSymbols = 26;
  localparam int TimerBits      = 16;
  localparam int AddrBits       = 2 * AddressSymbols;
  localparam int AddrRegBits    = 52;
  localparam int PayloadBits    = 6;
  localparam logic [31:0] TimerMax = 32'((64'd1 << TimerBits) - 64'd1);

  // Stream widths
  localparam int InDataW  = 16;
  localparam int OutDataW = 8;

  // Configuration port
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 52;
  localparam logic [CfgAddrW-1:0] CfgShortTicks  = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgLongTicks   = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgInitTicks   = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgGapTicks    = 3'd3;
  localparam logic [CfgAddrW-1:0] CfgAddressCode = 3'd4;

  // Register reset values
  localparam logic [15:0] ShortTicksRst = 16'd200;
  localparam logic [15:0] LongTicksRst  = 16'd1000;
  localparam logic [15:0] InitTicksRst  = 16'd2000;
  localparam logic [15:0] GapTicksRst   = 16'd8000;
  localparam logic [AddrRegBits-1:0] AddressCodeRst = 52'd3098127414377403;

  // Item kind carried in tuser
  localparam logic ModeTick  = 1'b0;
  localparam logic ModeStart = 1'b1;

  typedef enum logic [1:0] {
    PartInit    = 2'd0,
    PartAddr    = 2'd1,
    PartPayload = 2'd2,
    PartEnd     = 2'd3
  } frame_part_e;

  // One input beat, unpacked
  typedef struct packed {
    logic       mode;
    logic [1:0] switch_state;
    logic [1:0] group_code;
    logic [1:0] unit_code;
    logic [7:0] repeat_count;
  } item_t;

  // One result beat
  typedef struct packed {
    logic start_rejected;
    logic command_done;
    logic busy_res;
    logic line_level;
  } result_t;

  // Clamp a segment length: zero lasts one tick, saturate at the timer max
  function automatic logic [TimerBits-1:0] fit_timer(input logic [15:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) w = 32'd1;
    if (w > TimerMax) w = TimerMax;
    return w[TimerBits-1:0];
  endfunction

endpackage

/* rtl/core/ootx_seq.sv */
// ----------------------------------------------------------------------------
// ootx_seq
// Frame sequencer: config registers, segment timer and frame position.
// Updates once per accepted beat and returns that beat's result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ootx_seq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config writes
  input  logic                                cfg_we_i,
  input  logic [ootx_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  logic [ootx_pkg::CfgDataW-1:0]       cfg_data_i,
  // accepted item
  input  logic                                item_valid_i,
  input  ootx_pkg::item_t                     item_i,
  output ootx_pkg::result_t                   result_o
);

  localparam int Tb = ootx_pkg::TimerBits;

  // Config registers
  logic [15:0] short_q, long_q, init_q, gap_q;
  logic [ootx_pkg::AddrRegBits-1:0] addr_code_q;

  // Sequencer state
  logic                   active_q, active_d;
  logic [Tb-1:0]          ticks_q, ticks_d;
  logic [5:0]             bp_q, bp_d;
  ootx_pkg::frame_part_e  part_q, part_d;
  logic [1:0]             seg_q, seg_d;
  logic [7:0]             reps_q, reps_d;
  logic [ootx_pkg::PayloadBits-1:0] payload_q, payload_d;

  // Bit being sent at a given frame position
  function automatic logic cur_bit(input ootx_pkg::frame_part_e part,
                                   input logic [5:0] bp,
                                   input logic [ootx_pkg::AddrRegBits-1:0] code,
                                   input logic [ootx_pkg::PayloadBits-1:0] pl);
    logic [6:0] k;
    logic [2:0] pidx;
    logic       b;
    k    = 7'(ootx_pkg::AddrBits - 1) - {1'b0, bp};
    pidx = 3'd5 - bp[2:0];
    b    = 1'b0;
    if (part == ootx_pkg::PartAddr) begin
      if (k < 7'(ootx_pkg::AddrRegBits)) b = code[k[5:0]];
    end else if (part == ootx_pkg::PartPayload) begin
      if (pidx <= 3'd5) b = pl[pidx];
    end
    return b;
  endfunction

  // Clamped length of a segment
  function automatic logic [Tb-1:0] seg_len(input ootx_pkg::frame_part_e part,
                                            input logic [1:0] seg,
                                            input logic bit_val,
                                            input logic [15:0] s_t,
                                            input logic [15:0] l_t,
                                            input logic [15:0] i_t,
                                            input logic [15:0] g_t);
    logic [15:0] len;
    if (part == ootx_pkg::PartInit) begin
      len = (seg == 2'd0) ? s_t : i_t;
    end else if (part == ootx_pkg::PartEnd) begin
      len = (seg == 2'd0) ? s_t : g_t;
    end else if (seg == 2'd1) begin
      len = bit_val ? l_t : s_t;
    end else if (seg == 2'd3) begin
      len = bit_val ? s_t : l_t;
    end else begin
      len = s_t;
    end
    return ootx_pkg::fit_timer(len);
  endfunction

  // Config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q     <= ootx_pkg::ShortTicksRst;
      long_q      <= ootx_pkg::LongTicksRst;
      init_q      <= ootx_pkg::InitTicksRst;
      gap_q       <= ootx_pkg::GapTicksRst;
      addr_code_q <= ootx_pkg::AddressCodeRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        ootx_pkg::CfgShortTicks:  short_q     <= cfg_data_i[15:0];
        ootx_pkg::CfgLongTicks:   long_q      <= cfg_data_i[15:0];
        ootx_pkg::CfgInitTicks:   init_q      <= cfg_data_i[15:0];
        ootx_pkg::CfgGapTicks:    gap_q       <= cfg_data_i[15:0];
        ootx_pkg::CfgAddressCode: addr_code_q <= cfg_data_i[ootx_pkg::AddrRegBits-1:0];
        default: ;
      endcase
    end
  end

  // Next state and result for one beat
  always_comb begin
    logic       frame_end;
    logic [1:0] last_seg;
    logic       nb;
    active_d  = active_q;
    ticks_d   = ticks_q;
    bp_d      = bp_q;
    part_d    = part_q;
    seg_d     = seg_q;
    reps_d    = reps_q;
    payload_d = payload_q;
    result_o  = '0;
    frame_end = 1'b0;
    last_seg  = ((part_q == ootx_pkg::PartInit) || (part_q == ootx_pkg::PartEnd)) ? 2'd1 : 2'd3;
    nb        = 1'b0;

    if (item_valid_i) begin
      if (item_i.mode == ootx_pkg::ModeStart) begin
        if (active_q) begin
          result_o.start_rejected = 1'b1;
          result_o.busy_res       = 1'b1;
        end else begin
          payload_d = {item_i.switch_state, item_i.group_code, item_i.unit_code};
          if (item_i.repeat_count == 8'd0) begin
            result_o.command_done = 1'b1;
          end else begin
            reps_d            = item_i.repeat_count;
            active_d          = 1'b1;
            result_o.busy_res = 1'b1;
            part_d            = ootx_pkg::PartInit;
            seg_d             = 2'd0;
            bp_d              = 6'd0;
            ticks_d           = ootx_pkg::fit_timer(short_q);
          end
        end
      end else if (active_q) begin
        result_o.busy_res   = 1'b1;
        result_o.line_level = ~seg_q[0];
        if (ticks_q > Tb'(1)) begin
          ticks_d = ticks_q - Tb'(1);
        end else begin
          // step to the next segment
          if (seg_q < last_seg) begin
            seg_d = seg_q + 2'd1;
          end else begin
            seg_d = 2'd0;
            case (part_q)
              ootx_pkg::PartInit: begin
                part_d = ootx_pkg::PartAddr;
                bp_d   = 6'd0;
              end
              ootx_pkg::PartAddr: begin
                if (({1'b0, bp_q} + 7'd1) < 7'(ootx_pkg::AddrBits)) begin
                  bp_d = bp_q + 6'd1;
                end else begin
                  part_d = ootx_pkg::PartPayload;
                  bp_d   = 6'd0;
                end
              end
              ootx_pkg::PartPayload: begin
                if (bp_q < 6'd5) begin
                  bp_d = bp_q + 6'd1;
                end else begin
                  part_d = ootx_pkg::PartEnd;
                  bp_d   = 6'd0;
                end
              end
              default: frame_end = 1'b1;
            endcase
          end

          if (!frame_end) begin
            nb      = cur_bit(part_d, bp_d, addr_code_q, payload_q);
            ticks_d = seg_len(part_d, seg_d, nb, short_q, long_q, init_q, gap_q);
          end else begin
            reps_d = reps_q - 8'd1;
            part_d = ootx_pkg::PartInit;
            seg_d  = 2'd0;
            bp_d   = 6'd0;
            if (reps_d == 8'd0) begin
              active_d              = 1'b0;
              result_o.command_done = 1'b1;
              ticks_d               = '0;
            end else begin
              ticks_d = ootx_pkg::fit_timer(short_q);
            end
          end
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      ticks_q   <= '0;
      bp_q      <= '0;
      part_q    <= ootx_pkg::PartInit;
      seg_q     <= '0;
      reps_q    <= '0;
      payload_q <= '0;
    end else begin
      active_q  <= active_d;
      ticks_q   <= ticks_d;
      bp_q      <= bp_d;
      part_q    <= part_d;
      seg_q     <= seg_d;
      reps_q    <= reps_d;
      payload_q <= payload_d;
    end
  end

  // Checks
  `ASSERT_IMPLIES(a_timer_loaded, clk_i, rst_ni, active_q, ticks_q != '0)
  `ASSERT_IMPLIES(a_idle_parked, clk_i, rst_ni, !active_q,
                  (part_q == ootx_pkg::PartInit) && (seg_q == 2'd0) && (bp_q == 6'd0))
  `ASSERT_IMPLIES(a_pulse_two_segs, clk_i, rst_ni,
                  (part_q == ootx_pkg::PartInit) || (part_q == ootx_pkg::PartEnd),
                  seg_q <= 2'd1)
  `ASSERT_NEXT(a_reject_keeps_busy, clk_i, rst_ni,
               item_valid_i && (item_i.mode == ootx_pkg::ModeStart) && active_q, active_q)

endmodule

/* rtl/core/ootx_skid.sv */
// ----------------------------------------------------------------------------
// ootx_skid
// Output register plus one skid entry for the result stream; ready to the
// upstream side comes from a register only.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ootx_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ootx_pkg::result_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ootx_pkg::result_t out_data_o
);

  logic              out_valid_q, skid_valid_q;
  ootx_pkg::result_t out_q, skid_q;
  logic              in_fire, slot_free;

  assign in_ready_o  = ~skid_valid_q;
  assign in_fire     = in_valid_i & in_ready_o;
  assign slot_free   = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q  <= skid_valid_q | in_fire;
      skid_valid_q <= 1'b0;
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      out_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (in_fire) begin
      skid_q <= in_data_i;
    end
  end

  // Checks
  `ASSERT_IMPLIES(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `ASSERT_NEXT(a_stall_to_skid, clk_i, rst_ni, in_fire && out_valid_q && !out_ready_i,
               skid_valid_q)
  `ASSERT_NEXT(a_skid_drains, clk_i, rst_ni, skid_valid_q && out_ready_i,
               out_valid_q && !skid_valid_q)

endmodule

/* rtl/core/ook_remote_frame_transmitter.sv */
// ----------------------------------------------------------------------------
// ook_remote_frame_transmitter
// On/off keyed remote frame transmitter: one tick item in, one line level out.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake                     Contents
// s_axis   in   s_axis_tvalid/s_axis_tready   tuser: mode; tdata: command
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata: level/busy/reject; tlast: done
// cfg      in   cfg_valid_i/cfg_ready_o       cfg_addr_i index, cfg_data_i value
//
// One beat is accepted per cycle while s_axis_tready is high; its result is
// registered, in the skid entry while m_axis stalls. The whole update (timer
// count, segment step, next segment length) sits between beat and result register.
// s_axis_tready falls only while the skid entry holds a stalled result.
// Reset loads the default timings and address and parks the sequencer idle.
// Config writes are always taken (cfg_ready_o is tied high).
// ----------------------------------------------------------------------------
module ook_remote_frame_transmitter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [1:0] switch_state, [3:2] group_code, [5:4] unit_code, [13:6] repeat_count
  input  logic [ootx_pkg::InDataW-1:0]      s_axis_tdata,
  // [0] mode
  input  logic                              s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] line_level, [1] busy_res, [2] start_rejected
  output logic [ootx_pkg::OutDataW-1:0]     m_axis_tdata,
  // command_done
  output logic                              m_axis_tlast,
  // config write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ootx_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [ootx_pkg::CfgDataW-1:0]     cfg_data_i
);

  ootx_pkg::item_t   item;
  ootx_pkg::result_t result, out_res;
  logic              in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = s_axis_tvalid & s_axis_tready;

  // Unpack the input beat
  assign item.mode         = s_axis_tuser;
  assign item.switch_state = s_axis_tdata[1:0];
  assign item.group_code   = s_axis_tdata[3:2];
  assign item.unit_code    = s_axis_tdata[5:4];
  assign item.repeat_count = s_axis_tdata[13:6];

  ootx_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (in_fire),
    .item_i       (item),
    .result_o     (result)
  );

  ootx_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (result),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  // Pack the result beat
  assign m_axis_tdata = {5'b0, out_res.start_rejected, out_res.busy_res, out_res.line_level};
  assign m_axis_tlast = out_res.command_done;

endmodule
